// ===== rtl/core/input_event_fifo_unit_macros.svh =====
// Assertion macros for the input event FIFO checker.
`ifndef INPUT_EVENT_FIFO_UNIT_MACROS_SVH
`define INPUT_EVENT_FIFO_UNIT_MACROS_SVH

// Checked at every edge outside reset.
`define IEF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("input event FIFO assertion failed");

// Checked at every edge, reset included.
`define IEF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("input event FIFO assertion failed");

`endif

// ===== rtl/core/iefifo_pkg.sv =====
// Package with the sizes, codes and marker constants of the input event FIFO.
package iefifo_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W      = 32;

    typedef logic [1:0]        kind_t;
    typedef logic [1:0]        status_t;
    typedef logic [WORD_W-1:0] word_t;

    localparam kind_t KIND_CURSOR  = 2'd0;
    localparam kind_t KIND_CLICK   = 2'd1;
    localparam kind_t KIND_KEY     = 2'd2;
    localparam kind_t KIND_DEQUEUE = 2'd3;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    localparam word_t MARK_CURSOR = 32'h8000_0000;
    localparam word_t MARK_CLICK  = 32'h4000_0000;
    localparam word_t MARK_KEY    = 32'h2000_0000;

endpackage

// ===== rtl/core/iefifo_ram.sv =====
// Generic single-port-write, registered-read RAM that holds the queued words.
module iefifo_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/iefifo_pack.sv =====
// Event word packer: builds the tagged 32-bit word for cursor, click and key events; other kinds give zero.
module iefifo_pack
    import iefifo_pkg::*;
(
    input  kind_t        kind,
    input  logic [15:0]  cursor_x,
    input  logic [15:0]  cursor_y,
    input  logic         left_button,
    input  logic         right_button,
    input  logic         middle_button,
    input  logic [7:0]   key_code,
    input  logic         key_released,
    input  logic         shift_held,
    input  logic         ctrl_held,
    output word_t        word
);

    always_comb begin
        unique case (kind)
            KIND_CURSOR: begin
                word = MARK_CURSOR | {cursor_x, cursor_y};
            end
            KIND_CLICK: begin
                word = MARK_CLICK | {29'd0, left_button, right_button, middle_button};
            end
            KIND_KEY: begin
                word = MARK_KEY | {21'd0, key_released, shift_held, ctrl_held, key_code};
            end
            default: begin
                word = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/input_event_fifo_unit.sv =====
// Input event FIFO top level: pointers, occupancy, slot RAM and result register.
// Push items and failed dequeues: result valid in the cycle after acceptance, one item per
// cycle while each result is taken. Successful dequeue: the word passes through the RAM read
// register and then the result register; no new item is taken in the cycle after it.
// Reset clears pointers, occupancy and the result valid; the slot RAM is not cleared.
module input_event_fifo_unit
    import iefifo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  kind_t       s_kind,
    input  logic [15:0] s_cursor_x,
    input  logic [15:0] s_cursor_y,
    input  logic        s_left_button,
    input  logic        s_right_button,
    input  logic        s_middle_button,
    input  logic [7:0]  s_key_code,
    input  logic        s_key_released,
    input  logic        s_shift_held,
    input  logic        s_ctrl_held,
    output logic        m_valid,
    input  logic        m_ready,
    output status_t     m_status,
    output word_t       m_event_word
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic             pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg, m_status_next;
    word_t            m_word_reg, m_word_next;

    word_t            push_word;
    word_t            ram_rdata;
    logic             accept;
    logic             is_pop;
    logic             is_full;
    logic             is_empty;
    logic             do_push;
    logic             do_pop;

    iefifo_pack u_pack (
        .kind          (s_kind),
        .cursor_x      (s_cursor_x),
        .cursor_y      (s_cursor_y),
        .left_button   (s_left_button),
        .right_button  (s_right_button),
        .middle_button (s_middle_button),
        .key_code      (s_key_code),
        .key_released  (s_key_released),
        .shift_held    (s_shift_held),
        .ctrl_held     (s_ctrl_held),
        .word          (push_word)
    );

    assign s_ready  = !pend_reg && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_pop   = (s_kind == KIND_DEQUEUE);
    assign is_full  = (occ_reg == DEPTH_CNT);
    assign is_empty = (occ_reg == '0);
    assign do_push  = accept && !is_pop && !is_full;
    assign do_pop   = accept && is_pop && !is_empty;

    iefifo_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data (push_word),
        .rd_en   (do_pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        occ_next      = occ_reg;
        pend_next     = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_word_next   = m_word_reg;

        if (pend_reg) begin
            m_valid_next  = 1'b1;
            m_status_next = STATUS_OK;
            m_word_next   = ram_rdata;
        end

        if (accept) begin
            if (is_pop) begin
                if (is_empty) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_EMPTY;
                    m_word_next   = '0;
                end else begin
                    pend_next   = 1'b1;
                    rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    occ_next    = occ_reg - 1'b1;
                end
            end else begin
                m_valid_next = 1'b1;
                m_word_next  = '0;
                if (is_full) begin
                    m_status_next = STATUS_FULL;
                end else begin
                    m_status_next = STATUS_OK;
                    wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    occ_next      = occ_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            occ_reg     <= occ_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_word_reg   <= m_word_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_event_word = m_word_reg;

endmodule

// ===== rtl/core/iefifo_checker.sv =====
// Port-level assertion checker for the input event FIFO and its bind statement.
`include "input_event_fifo_unit_macros.svh"

module iefifo_checker
    import iefifo_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input kind_t       s_kind,
    input logic        m_valid,
    input logic        m_ready,
    input status_t     m_status,
    input word_t       m_event_word
);

    // A result that is not taken holds its value.
    `IEF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_event_word))

    // Failed pushes and dequeues carry a zero word.
    `IEF_ASSERT(a_fail_zero, m_valid && m_status != STATUS_OK |-> m_event_word == '0)

    // A push item gives its result, with a zero word, in the next cycle.
    `IEF_ASSERT(a_push_result, s_valid && s_ready && s_kind != KIND_DEQUEUE |=> m_valid && m_event_word == '0 && m_status != STATUS_EMPTY)

    // Reset leaves no result pending.
    `IEF_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid)

endmodule

bind input_event_fifo_unit iefifo_checker u_iefifo_checker (.*);

// ===== dv/tb_input_event_fifo_unit.sv =====
// Self-checking testbench for the input event FIFO: packs, queues and pops event words.
`timescale 1ns / 1ps

module tb_input_event_fifo_unit;
    import iefifo_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [15:0] cursor_x;
        logic [15:0] cursor_y;
        logic        left_button;
        logic        right_button;
        logic        middle_button;
        logic [7:0]  key_code;
        logic        key_released;
        logic        shift_held;
        logic        ctrl_held;
    } input_item_t;

    typedef struct {
        status_t status;
        word_t   event_word;
    } fifo_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    kind_t       s_kind;
    logic [15:0] s_cursor_x;
    logic [15:0] s_cursor_y;
    logic        s_left_button;
    logic        s_right_button;
    logic        s_middle_button;
    logic [7:0]  s_key_code;
    logic        s_key_released;
    logic        s_shift_held;
    logic        s_ctrl_held;
    logic        m_valid;
    logic        m_ready;
    status_t     m_status;
    word_t       m_event_word;

    fifo_result_t pending_results[$];

    word_t            shadow_slots[QUEUE_DEPTH];
    logic [PTR_W-1:0] shadow_rd_ptr;
    logic [PTR_W-1:0] shadow_wr_ptr;
    int               shadow_count;

    int  err_count;
    int  items_sent;
    int  pops_ok;
    int  full_seen;
    int  empty_seen;
    int  results_checked;
    bit  idle_on;

    input_event_fifo_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_cursor_x      (s_cursor_x),
        .s_cursor_y      (s_cursor_y),
        .s_left_button   (s_left_button),
        .s_right_button  (s_right_button),
        .s_middle_button (s_middle_button),
        .s_key_code      (s_key_code),
        .s_key_released  (s_key_released),
        .s_shift_held    (s_shift_held),
        .s_ctrl_held     (s_ctrl_held),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_event_word    (m_event_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic word_t pack_event(input input_item_t it);
        word_t w;
        case (it.kind)
            KIND_CURSOR: w = MARK_CURSOR | {it.cursor_x, it.cursor_y};
            KIND_CLICK:  w = MARK_CLICK | {29'd0, it.left_button, it.right_button,
                                           it.middle_button};
            default:     w = MARK_KEY | {21'd0, it.key_released, it.shift_held,
                                         it.ctrl_held, it.key_code};
        endcase
        return w;
    endfunction

    function automatic fifo_result_t fifo_outcome(input input_item_t it);
        fifo_result_t r;
        r.status     = STATUS_OK;
        r.event_word = '0;
        if (it.kind == KIND_DEQUEUE) begin
            if (shadow_count == 0) begin
                r.status = STATUS_EMPTY;
                empty_seen++;
            end else begin
                r.event_word  = shadow_slots[shadow_rd_ptr];
                shadow_rd_ptr = shadow_rd_ptr + 1'b1;
                shadow_count--;
                pops_ok++;
            end
        end else if (shadow_count >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
            full_seen++;
        end else begin
            shadow_slots[shadow_wr_ptr] = pack_event(it);
            shadow_wr_ptr = shadow_wr_ptr + 1'b1;
            shadow_count++;
        end
        return r;
    endfunction

    function automatic input_item_t random_item(input kind_t k);
        input_item_t it;
        it.kind          = k;
        it.cursor_x      = 16'($urandom);
        it.cursor_y      = 16'($urandom);
        it.left_button   = 1'($urandom);
        it.right_button  = 1'($urandom);
        it.middle_button = 1'($urandom);
        it.key_code      = 8'($urandom);
        it.key_released  = 1'($urandom);
        it.shift_held    = 1'($urandom);
        it.ctrl_held     = 1'($urandom);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endtask

    task automatic send_item(input input_item_t it);
        if (idle_on && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= it.kind;
        s_cursor_x      <= it.cursor_x;
        s_cursor_y      <= it.cursor_y;
        s_left_button   <= it.left_button;
        s_right_button  <= it.right_button;
        s_middle_button <= it.middle_button;
        s_key_code      <= it.key_code;
        s_key_released  <= it.key_released;
        s_shift_held    <= it.shift_held;
        s_ctrl_held     <= it.ctrl_held;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(fifo_outcome(it));
        items_sent++;
    endtask

    task automatic send_dequeue();
        send_item(random_item(KIND_DEQUEUE));
    endtask

    task automatic send_fields(input kind_t k, input logic [15:0] x, input logic [15:0] y,
                               input logic [2:0] buttons, input logic [7:0] code,
                               input logic [2:0] mods);
        input_item_t it;
        it = random_item(k);
        if (k == KIND_CURSOR) begin
            it.cursor_x = x;
            it.cursor_y = y;
        end
        {it.left_button, it.right_button, it.middle_button} = buttons;
        it.key_code = code;
        {it.key_released, it.shift_held, it.ctrl_held} = mods;
        send_item(it);
    endtask

    always @(posedge aclk) begin
        fifo_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, m_event_word);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_status !== exp_r.status)
                    report_mismatch("status", 32'(exp_r.status), 32'(m_status));
                if (m_event_word !== exp_r.event_word)
                    report_mismatch("event_word", exp_r.event_word, m_event_word);
            end
        end
        m_ready <= idle_on ? ($urandom_range(99) >= 12) : 1'b1;
    end

    task automatic test_empty_dequeue();
        send_dequeue();
        send_dequeue();
    endtask

    task automatic test_event_packing();
        send_fields(KIND_CURSOR, 16'h0000, 16'h0000, 3'b000, 8'h00, 3'b000);
        send_fields(KIND_CURSOR, 16'hFFFF, 16'hFFFF, 3'b111, 8'hFF, 3'b111);
        send_fields(KIND_CURSOR, 16'h7FFF, 16'h8000, 3'b010, 8'h5A, 3'b101);
        send_fields(KIND_CLICK, 16'h0000, 16'h0000, 3'b000, 8'hFF, 3'b111);
        send_fields(KIND_CLICK, 16'h0000, 16'h0000, 3'b111, 8'h00, 3'b000);
        send_fields(KIND_CLICK, 16'h0000, 16'h0000, 3'b101, 8'hA5, 3'b010);
        send_fields(KIND_KEY, 16'hFFFF, 16'hFFFF, 3'b111, 8'h00, 3'b000);
        send_fields(KIND_KEY, 16'h0000, 16'h0000, 3'b000, 8'hFF, 3'b111);
        send_fields(KIND_KEY, 16'h1234, 16'h5678, 3'b010, 8'h80, 3'b100);
        while (shadow_count > 0) send_dequeue();
        send_dequeue();
    endtask

    task automatic test_fill_overflow();
        while (shadow_count < QUEUE_DEPTH) send_item(random_item(kind_t'($urandom_range(2))));
        repeat (3) send_item(random_item(kind_t'($urandom_range(2))));
        repeat (QUEUE_DEPTH + 2) send_dequeue();
    endtask

    task automatic test_random_mix();
        int push_pct;
        for (int seg = 0; seg < 8; seg++) begin
            idle_on = (seg >= 4);
            case ($urandom_range(2))
                0:       push_pct = 25;
                1:       push_pct = 50;
                default: push_pct = 80;
            endcase
            repeat (10) begin
                if ($urandom_range(99) < push_pct)
                    send_item(random_item(kind_t'($urandom_range(2))));
                else
                    send_dequeue();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        err_count       = 0;
        items_sent      = 0;
        pops_ok         = 0;
        full_seen       = 0;
        empty_seen      = 0;
        results_checked = 0;
        idle_on         = 1'b1;
        shadow_rd_ptr   = '0;
        shadow_wr_ptr   = '0;
        shadow_count    = 0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_kind          <= KIND_CURSOR;
        s_cursor_x      <= '0;
        s_cursor_y      <= '0;
        s_left_button   <= 1'b0;
        s_right_button  <= 1'b0;
        s_middle_button <= 1'b0;
        s_key_code      <= '0;
        s_key_released  <= 1'b0;
        s_shift_held    <= 1'b0;
        s_ctrl_held     <= 1'b0;
        m_ready         <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_dequeue();
        test_event_packing();
        test_fill_overflow();
        test_random_mix();

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 32'd0, 32'(pending_results.size()));

        $display("Sent %0d items and checked %0d results: %0d words popped.",
                 items_sent, results_checked, pops_ok);
        $display("The queue was found full %0d times and empty %0d times.",
                 full_seen, empty_seen);
        if (err_count == 0) begin
            $display("[input_event_fifo_unit] OK");
        end else begin
            $display("[input_event_fifo_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[input_event_fifo_unit] ERROR");
        $finish;
    end

endmodule

// ===== input_event_fifo_unit.f =====
+incdir+rtl/core
rtl/core/iefifo_pkg.sv
rtl/core/iefifo_ram.sv
rtl/core/iefifo_pack.sv
rtl/core/input_event_fifo_unit.sv
rtl/core/iefifo_checker.sv
dv/tb_input_event_fifo_unit.sv
